### sv/adsr_pkg.sv
// Shared constants, codes and types for the ADSR envelope generator.
`default_nettype none

package adsr_pkg;

  // Field and register widths
  localparam int TIME_BITS  = 32;
  localparam int LEVEL_BITS = 16;
  localparam int DUR_BITS   = 24;
  localparam int CFG_DATA_BITS = 32;
  localparam int NUM_REGS   = 5;
  localparam int ADDR_BITS  = $clog2(NUM_REGS * 4);
  localparam int IDX_BITS   = ADDR_BITS - 2;
  localparam int CNT_BITS   = $clog2(LEVEL_BITS);

  // Levels at or below this are forced to zero (1e-4 of full scale)
  localparam logic [LEVEL_BITS-1:0] LEVEL_THRESH = LEVEL_BITS'((2 ** LEVEL_BITS) / 10000);
  localparam logic [LEVEL_BITS-1:0] LEVEL_MAX    = '1;

  // Register reset values
  localparam logic [DUR_BITS-1:0]   ATTACK_RST  = DUR_BITS'(4800);
  localparam logic [DUR_BITS-1:0]   DECAY_RST   = DUR_BITS'(480);
  localparam logic [DUR_BITS-1:0]   RELEASE_RST = DUR_BITS'(9600);
  localparam logic [LEVEL_BITS-1:0] SUSTAIN_RST = LEVEL_BITS'(((2 ** LEVEL_BITS) * 4) / 5);
  localparam logic [LEVEL_BITS-1:0] PEAK_RST    = LEVEL_MAX;

  // Register indexes
  localparam logic [IDX_BITS-1:0] REG_ATTACK  = IDX_BITS'(0);
  localparam logic [IDX_BITS-1:0] REG_DECAY   = IDX_BITS'(1);
  localparam logic [IDX_BITS-1:0] REG_RELEASE = IDX_BITS'(2);
  localparam logic [IDX_BITS-1:0] REG_SUSTAIN = IDX_BITS'(3);
  localparam logic [IDX_BITS-1:0] REG_PEAK    = IDX_BITS'(4);

  // Input modes
  localparam logic [1:0] MODE_SAMPLE   = 2'd0;
  localparam logic [1:0] MODE_NOTE_ON  = 2'd1;
  localparam logic [1:0] MODE_NOTE_OFF = 2'd2;

  typedef enum logic [1:0] {
    PH_ATTACK  = 2'd0,
    PH_DECAY   = 2'd1,
    PH_SUSTAIN = 2'd2,
    PH_RELEASE = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } st_t;

endpackage

`default_nettype wire

### sv/adsr_in_if.sv
// Input channel: sample time and note mode.
`default_nettype none

interface adsr_in_if
  import adsr_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [1:0]           mode;
  logic [TIME_BITS-1:0] sample_time;

  modport source (output valid, output mode, output sample_time, input ready);
  modport sink   (input valid, input mode, input sample_time, output ready);
endinterface

`default_nettype wire

### sv/adsr_out_if.sv
// Result channel: envelope amplitude and phase.
`default_nettype none

interface adsr_out_if
  import adsr_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [LEVEL_BITS-1:0] amplitude;
  logic [1:0]            phase;

  modport source (output valid, output amplitude, output phase, input ready);
  modport sink   (input valid, input amplitude, input phase, output ready);
endinterface

`default_nettype wire

### sv/adsr_envelope_generator.sv
// Top level of the linear ADSR envelope generator.
//
//   channel  direction  payload                       transaction when
//   in_ch    sink       mode[1:0], sample_time[31:0]  valid & ready
//   out_ch   source     amplitude[15:0], phase[1:0]   valid & ready
//   cfg_*    APB slave  5 registers at 4*i            psel & penable & pwrite
//
// Ramp item: decode, multiply, 16 divider steps and completion, then back to
// idle for the next transaction. Sustain, finished release and zero attack
// skip the multiply and the divider and go from decode straight to completion.
// Reset (rst_n low, synchronous) restores registers and releases the gate.
// in_ch.ready is high only while idle; the output register holds a result
// until taken, and a finished result waits in place if it is still full.
`default_nettype none

module adsr_envelope_generator
  import adsr_pkg::*;
(
  input  wire                      clk,
  input  wire                      rst_n,
  adsr_in_if.sink                  in_ch,
  adsr_out_if.source               out_ch,
  input  wire                      cfg_psel,
  input  wire                      cfg_penable,
  input  wire                      cfg_pwrite,
  input  wire  [ADDR_BITS-1:0]     cfg_paddr,
  input  wire  [CFG_DATA_BITS-1:0] cfg_pwdata,
  output logic [CFG_DATA_BITS-1:0] cfg_prdata,
  output logic                     cfg_pready
);

  // Configuration registers
  logic [DUR_BITS-1:0]   attack_r, decay_r, release_r;
  logic [LEVEL_BITS-1:0] sustain_r, peak_r;
  logic [IDX_BITS-1:0]   cfg_idx;
  logic                  cfg_wr;

  // Envelope state
  logic                 gate_on_r;
  logic [TIME_BITS-1:0] on_time_r, off_time_r, now_r;

  // Sequencer and datapath
  st_t                   state_r, state_nxt;
  phase_t                phase_r;
  logic [LEVEL_BITS-1:0] base_r;
  logic                  sub_r;
  logic [DUR_BITS-1:0]   x_r;
  logic [LEVEL_BITS-1:0] lvl_r;
  logic [DUR_BITS-1:0]   div_r;
  logic [DUR_BITS-1:0]   rem_r;
  logic [LEVEL_BITS-1:0] q_r;
  logic [CNT_BITS-1:0]   cnt_r;
  logic                  div_last;

  // Output register
  logic                  out_valid_r;
  logic [LEVEL_BITS-1:0] out_amp_r;
  phase_t                out_phase_r;

  logic accept, load_out;

  assign accept = in_ch.valid && in_ch.ready;

  // APB register file
  assign cfg_idx    = cfg_paddr[ADDR_BITS-1:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_r  <= ATTACK_RST;
      decay_r   <= DECAY_RST;
      release_r <= RELEASE_RST;
      sustain_r <= SUSTAIN_RST;
      peak_r    <= PEAK_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_ATTACK:  attack_r  <= cfg_pwdata[DUR_BITS-1:0];
        REG_DECAY:   decay_r   <= cfg_pwdata[DUR_BITS-1:0];
        REG_RELEASE: release_r <= cfg_pwdata[DUR_BITS-1:0];
        REG_SUSTAIN: sustain_r <= cfg_pwdata[LEVEL_BITS-1:0];
        REG_PEAK:    peak_r    <= cfg_pwdata[LEVEL_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_ATTACK:  cfg_prdata = CFG_DATA_BITS'(attack_r);
      REG_DECAY:   cfg_prdata = CFG_DATA_BITS'(decay_r);
      REG_RELEASE: cfg_prdata = CFG_DATA_BITS'(release_r);
      REG_SUSTAIN: cfg_prdata = CFG_DATA_BITS'(sustain_r);
      REG_PEAK:    cfg_prdata = CFG_DATA_BITS'(peak_r);
      default:     cfg_prdata = '0;
    endcase
  end

  // Note events: record the time and move the gate at acceptance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gate_on_r  <= 1'b0;
      on_time_r  <= '0;
      off_time_r <= '0;
    end else if (accept) begin
      case (in_ch.mode)
        MODE_NOTE_ON: begin
          gate_on_r <= 1'b1;
          on_time_r <= in_ch.sample_time;
        end
        MODE_NOTE_OFF: begin
          gate_on_r  <= 1'b0;
          off_time_r <= in_ch.sample_time;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      now_r <= in_ch.sample_time;
    end
  end

  // Phase decode: pick phase, ramp operands, or a level needing no divide
  logic [TIME_BITS-1:0]  elapsed;
  logic [DUR_BITS:0]     ad_sum;
  phase_t                dec_phase;
  logic                  dec_direct;
  logic                  dec_sub;
  logic [LEVEL_BITS-1:0] dec_base, dec_lvl;
  logic [DUR_BITS-1:0]   dec_x, dec_div;

  assign elapsed = now_r - (gate_on_r ? on_time_r : off_time_r);
  assign ad_sum  = {1'b0, attack_r} + {1'b0, decay_r};

  always_comb begin
    dec_phase  = PH_RELEASE;
    dec_direct = 1'b0;
    dec_sub    = 1'b0;
    dec_base   = '0;
    dec_lvl    = '0;
    dec_x      = elapsed[DUR_BITS-1:0];
    dec_div    = release_r;
    if (gate_on_r) begin
      if (elapsed <= TIME_BITS'(attack_r)) begin
        dec_phase = PH_ATTACK;
        dec_lvl   = peak_r;
        dec_div   = attack_r;
        if (attack_r == '0) begin
          dec_direct = 1'b1;
          dec_base   = peak_r;
        end
      end else if (elapsed <= TIME_BITS'(ad_sum)) begin
        // ramp from peak toward sustain, either direction
        dec_phase = PH_DECAY;
        dec_base  = peak_r;
        dec_x     = elapsed[DUR_BITS-1:0] - attack_r;
        dec_div   = decay_r;
        dec_sub   = (sustain_r < peak_r);
        dec_lvl   = dec_sub ? (peak_r - sustain_r) : (sustain_r - peak_r);
      end else begin
        dec_phase  = PH_SUSTAIN;
        dec_direct = 1'b1;
        dec_base   = sustain_r;
      end
    end else begin
      if (elapsed >= TIME_BITS'(release_r)) begin
        dec_direct = 1'b1;
      end else begin
        dec_base = sustain_r;
        dec_lvl  = sustain_r;
        dec_sub  = 1'b1;
      end
    end
  end

  // Shared divider step: one restoring compare and subtract
  logic [DUR_BITS:0]                trial;
  logic                             trial_ge;
  logic [DUR_BITS:0]                trial_diff;
  logic [DUR_BITS+LEVEL_BITS-1:0]   prod;

  assign trial      = {rem_r, q_r[LEVEL_BITS-1]};
  assign trial_ge   = (trial >= {1'b0, div_r});
  assign trial_diff = trial - {1'b0, div_r};
  assign prod       = x_r * lvl_r;
  assign div_last   = (cnt_r == CNT_BITS'(LEVEL_BITS - 1));

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_DECODE: begin
        phase_r <= dec_phase;
        base_r  <= dec_base;
        sub_r   <= dec_sub;
        x_r     <= dec_x;
        lvl_r   <= dec_lvl;
        div_r   <= dec_div;
        q_r     <= '0;
        cnt_r   <= '0;
      end
      ST_MUL: begin
        rem_r <= prod[DUR_BITS+LEVEL_BITS-1:LEVEL_BITS];
        q_r   <= prod[LEVEL_BITS-1:0];
      end
      ST_DIV: begin
        rem_r <= trial_ge ? trial_diff[DUR_BITS-1:0] : trial[DUR_BITS-1:0];
        q_r   <= {q_r[LEVEL_BITS-2:0], trial_ge};
        cnt_r <= cnt_r + CNT_BITS'(1);
      end
      default: ;
    endcase
  end

  // Final level: combine base and quotient, threshold, saturate
  logic [LEVEL_BITS:0]   sum;
  logic [LEVEL_BITS-1:0] amp;

  assign sum = sub_r ? ({1'b0, base_r} - {1'b0, q_r}) : ({1'b0, base_r} + {1'b0, q_r});

  always_comb begin
    if (sum[LEVEL_BITS]) begin
      amp = LEVEL_MAX;
    end else if (sum[LEVEL_BITS-1:0] <= LEVEL_THRESH) begin
      amp = '0;
    end else begin
      amp = sum[LEVEL_BITS-1:0];
    end
  end

  // Sequencer: next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (accept) state_nxt = ST_DECODE;
      ST_DECODE: state_nxt = dec_direct ? ST_DONE : ST_MUL;
      ST_MUL:    state_nxt = ST_DIV;
      ST_DIV:    if (div_last) state_nxt = ST_DONE;
      ST_DONE:   if (load_out) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    in_ch.ready = (state_r == ST_IDLE);
    load_out    = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_amp_r   <= amp;
      out_phase_r <= phase_r;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.amplitude = out_amp_r;
  assign out_ch.phase     = out_phase_r;

  // Divider remainder stays below the divisor on every step
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < div_r))
    else $error("divider remainder not below divisor");

  // Divider moves to the completion state from its last quotient-bit step
  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && div_last) |=> (state_r == ST_DONE))
    else $error("divider did not finish on its last step");

  // A new result appears only from the completion state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result loaded outside completion state");

  // Release phase is reported only with the gate closed
  a_rel_gate: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && phase_r == PH_RELEASE) |-> !gate_on_r)
    else $error("release phase with gate open");

endmodule

`default_nettype wire

### verif/tb_adsr_envelope_generator.sv
// Self-checking testbench for the linear ADSR envelope generator.
`timescale 1ns / 1ps

module tb_adsr_envelope_generator
  import adsr_pkg::*;
;

  localparam int CYCLE_LIMIT       = 2_000_000;
  localparam int SETTLE_CYCLES     = 40;
  localparam int NUM_SETTINGS      = 7;
  localparam int ITEMS_PER_SETTING = 250;
  localparam int PRESSURE_AT       = 1000;
  localparam int PRESSURE_CYCLES   = 500;
  localparam int MAX_REPORTS       = 10;

  // Mode value the block treats as a plain sample
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  // Register indexes past the end of the map
  localparam logic [IDX_BITS-1:0] REG_SPARE      = IDX_BITS'(NUM_REGS);
  localparam logic [IDX_BITS-1:0] REG_LAST_SPARE = '1;
  localparam logic [DUR_BITS-1:0] DUR_MAX        = '1;

  typedef struct packed {
    logic [LEVEL_BITS-1:0] amplitude;
    phase_t                phase;
  } envelope_t;

  typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [1:0]            mode;
    logic [IDX_BITS-1:0]   reg_idx;
    logic [31:0]           value;     // sample time, or register data
    logic                  typed;     // expected result given in the row
    logic [LEVEL_BITS-1:0] amp;
    phase_t                phase;
  } dir_row_t;

  localparam int NUM_ROWS = 41;

  // Directed stimulus; typed rows carry results read straight off the spec
  localparam dir_row_t DIRECTED [NUM_ROWS] = '{
    // reset settings: released gate timed from tick 0
    '{ROW_ITEM, MODE_SAMPLE,   REG_ATTACK, 32'd0,          1'b1, 16'd52428, PH_RELEASE},
    '{ROW_ITEM, MODE_SAMPLE,   REG_ATTACK, 32'd9600,       1'b1, 16'd0,     PH_RELEASE},
    '{ROW_ITEM, MODE_SAMPLE,   REG_ATTACK, 32'd4800,       1'b0, 16'd0,     PH_RELEASE},
    '{ROW_ITEM, MODE_NOTE_ON,  REG_ATTACK, 32'd1000,       1'b1, 16'd0,     PH_ATTACK},
    '{ROW_ITEM, MODE_SAMPLE,   REG_ATTACK, 32'd5800,       1'b1, 16'd65535, PH_ATTACK},
    '{ROW_ITEM, MODE_SAMPLE,   REG_ATTACK, 32'd6280,       1'b1, 16'd52428, PH_DECAY},
    '{ROW_ITEM, MODE_SAMPLE,   REG_ATTACK, 32'd6281,       1'b1, 16'd52428, PH_SUSTAIN},
    '{ROW_ITEM, MODE_SAMPLE,   REG_ATTACK, 32'hFFFF_FFFF,  1'b0, 16'd0,     PH_SUSTAIN},
    '{ROW_ITEM, MODE_NOTE_OFF, REG_ATTACK, 32'd10000,      1'b1, 16'd52428, PH_RELEASE},
    '{ROW_ITEM, MODE_SAMPLE,   REG_ATTACK, 32'd12400,      1'b0, 16'd0,     PH_RELEASE},
    '{ROW_ITEM, MODE_UNUSED,   REG_ATTACK, 32'd19600,      1'b1, 16'd0,     PH_RELEASE},
    '{ROW_ITEM, MODE_NOTE_ON,  REG_ATTACK, 32'hFFFF_FF00,  1'b1, 16'd0,     PH_ATTACK},
    '{ROW_ITEM, MODE_SAMPLE,   REG_ATTACK, 32'h0000_0100,  1'b0, 16'd0,     PH_ATTACK},
    // zero attack, decay and release
    '{ROW_CFG,  MODE_SAMPLE,   REG_ATTACK,  32'd0,         1'b0, 16'd0,     PH_ATTACK},
    '{ROW_CFG,  MODE_SAMPLE,   REG_DECAY,   32'd0,         1'b0, 16'd0,     PH_ATTACK},
    '{ROW_CFG,  MODE_SAMPLE,   REG_RELEASE, 32'd0,         1'b0, 16'd0,     PH_ATTACK},
    '{ROW_CFG,  MODE_SAMPLE,   REG_SUSTAIN, 32'h0000_1234, 1'b0, 16'd0,     PH_ATTACK},
    '{ROW_CFG,  MODE_SAMPLE,   REG_PEAK,    32'h0000_FFFF, 1'b0, 16'd0,     PH_ATTACK},
    '{ROW_ITEM, MODE_NOTE_ON,  REG_ATTACK, 32'd5,          1'b1, 16'd65535, PH_ATTACK},
    '{ROW_ITEM, MODE_SAMPLE,   REG_ATTACK, 32'd6,          1'b1, 16'h1234,  PH_SUSTAIN},
    '{ROW_ITEM, MODE_NOTE_OFF, REG_ATTACK, 32'd7,          1'b1, 16'd0,     PH_RELEASE},
    // wide writes with junk upper bits, longest ramps, writes past the map
    '{ROW_CFG,  MODE_SAMPLE,   REG_ATTACK,     32'hFF00_0003, 1'b0, 16'd0,  PH_ATTACK},
    '{ROW_CFG,  MODE_SAMPLE,   REG_DECAY,      32'hFFFF_FFFF, 1'b0, 16'd0,  PH_ATTACK},
    '{ROW_CFG,  MODE_SAMPLE,   REG_RELEASE,    32'hFFFF_FFFF, 1'b0, 16'd0,  PH_ATTACK},
    '{ROW_CFG,  MODE_SAMPLE,   REG_SUSTAIN,    32'hFFFF_0000, 1'b0, 16'd0,  PH_ATTACK},
    '{ROW_CFG,  MODE_SAMPLE,   REG_PEAK,       32'hABCD_FFFF, 1'b0, 16'd0,  PH_ATTACK},
    '{ROW_CFG,  MODE_SAMPLE,   REG_SPARE,      32'd0,         1'b0, 16'd0,  PH_ATTACK},
    '{ROW_CFG,  MODE_SAMPLE,   REG_LAST_SPARE, 32'hFFFF_FFFF, 1'b0, 16'd0,  PH_ATTACK},
    '{ROW_ITEM, MODE_NOTE_ON,  REG_ATTACK, 32'd100,        1'b1, 16'd0,     PH_ATTACK},
    '{ROW_ITEM, MODE_SAMPLE,   REG_ATTACK, 32'd103,        1'b1, 16'd65535, PH_ATTACK},
    '{ROW_ITEM, MODE_SAMPLE,   REG_ATTACK, 32'd104,        1'b0, 16'd0,     PH_DECAY},
    '{ROW_ITEM, MODE_SAMPLE,   REG_ATTACK, 32'h0100_0066,  1'b1, 16'd0,     PH_DECAY},
    '{ROW_ITEM, MODE_SAMPLE,   REG_ATTACK, 32'h0100_0067,  1'b1, 16'd0,     PH_SUSTAIN},
    '{ROW_ITEM, MODE_NOTE_OFF, REG_ATTACK, 32'h0200_0000,  1'b1, 16'd0,     PH_RELEASE},
    // levels straddling the zero threshold
    '{ROW_CFG,  MODE_SAMPLE,   REG_ATTACK,  32'd1,         1'b0, 16'd0,     PH_ATTACK},
    '{ROW_CFG,  MODE_SAMPLE,   REG_DECAY,   32'd1,         1'b0, 16'd0,     PH_ATTACK},
    '{ROW_CFG,  MODE_SAMPLE,   REG_SUSTAIN, 32'd6,         1'b0, 16'd0,     PH_ATTACK},
    '{ROW_CFG,  MODE_SAMPLE,   REG_PEAK,    32'd7,         1'b0, 16'd0,     PH_ATTACK},
    '{ROW_ITEM, MODE_NOTE_ON,  REG_ATTACK, 32'd50,         1'b1, 16'd0,     PH_ATTACK},
    '{ROW_ITEM, MODE_SAMPLE,   REG_ATTACK, 32'd51,         1'b1, 16'd7,     PH_ATTACK},
    '{ROW_ITEM, MODE_SAMPLE,   REG_ATTACK, 32'd53,         1'b1, 16'd0,     PH_SUSTAIN}
  };

  logic clk;
  logic rst_n;

  logic                     cfg_psel;
  logic                     cfg_penable;
  logic                     cfg_pwrite;
  logic [ADDR_BITS-1:0]     cfg_paddr;
  logic [CFG_DATA_BITS-1:0] cfg_pwdata;
  logic [CFG_DATA_BITS-1:0] cfg_prdata;
  logic                     cfg_pready;

  adsr_in_if  in_ch ();
  adsr_out_if out_ch ();

  adsr_envelope_generator dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Envelope predictor state: gate, note times and register shadows
  logic                  gate_open;
  logic [TIME_BITS-1:0]  note_on_tick;
  logic [TIME_BITS-1:0]  note_off_tick;
  logic [DUR_BITS-1:0]   atk_len;
  logic [DUR_BITS-1:0]   dec_len;
  logic [DUR_BITS-1:0]   rel_len;
  logic [LEVEL_BITS-1:0] sus_lvl;
  logic [LEVEL_BITS-1:0] pk_lvl;

  envelope_t expected_levels [$];
  envelope_t oldest_level;
  int        errors;
  int        items_sent;
  int        cycle_count;
  int        rx_hold;
  bit        pressure_done;
  bit        quiet;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Applies the note event of one item, then returns the envelope it samples
  function automatic envelope_t predict_envelope(input logic [1:0] mode,
                                                 input logic [TIME_BITS-1:0] now);
    envelope_t            res;
    logic [TIME_BITS-1:0] elapsed;
    logic [63:0]          el, a, d, r, s, p, lvl;
    if (mode == MODE_NOTE_ON) begin
      gate_open    = 1'b1;
      note_on_tick = now;
    end else if (mode == MODE_NOTE_OFF) begin
      gate_open     = 1'b0;
      note_off_tick = now;
    end
    a = 64'(atk_len);
    d = 64'(dec_len);
    r = 64'(rel_len);
    s = 64'(sus_lvl);
    p = 64'(pk_lvl);
    if (gate_open) begin
      elapsed = now - note_on_tick;
      el      = 64'(elapsed);
      if (el <= a) begin
        res.phase = PH_ATTACK;
        lvl = (a == 0) ? p : (el * p) / a;
      end else if (el <= a + d) begin
        res.phase = PH_DECAY;
        if (s >= p) lvl = p + ((el - a) * (s - p)) / d;
        else        lvl = p - ((el - a) * (p - s)) / d;
      end else begin
        res.phase = PH_SUSTAIN;
        lvl = s;
      end
    end else begin
      res.phase = PH_RELEASE;
      elapsed   = now - note_off_tick;
      el        = 64'(elapsed);
      lvl = (el >= r) ? 64'd0 : s - (el * s) / r;
    end
    if (lvl <= 64'(LEVEL_THRESH)) lvl = 0;
    if (lvl > 64'(LEVEL_MAX)) lvl = 64'(LEVEL_MAX);
    res.amplitude = lvl[LEVEL_BITS-1:0];
    return res;
  endfunction

  // Idle length: mostly short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(30, 150);
  endfunction

  // Ramp length: mostly short so every phase is reachable, sometimes huge
  function automatic logic [DUR_BITS-1:0] pick_duration();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return DUR_BITS'($urandom_range(1, 64));
    if (r < 90) return DUR_BITS'($urandom_range(1, 5000));
    return DUR_BITS'($urandom_range(1, 32'h00FF_FFFF));
  endfunction

  // APB write: setup, then access; shadow follows the register map
  task automatic write_reg(input logic [IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_BITS'({idx, 2'b00});
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_ATTACK:  atk_len = data[DUR_BITS-1:0];
      REG_DECAY:   dec_len = data[DUR_BITS-1:0];
      REG_RELEASE: rel_len = data[DUR_BITS-1:0];
      REG_SUSTAIN: sus_lvl = data[LEVEL_BITS-1:0];
      REG_PEAK:    pk_lvl  = data[LEVEL_BITS-1:0];
      default: ;
    endcase
  endtask

  // Wait for all outstanding results, then let the block settle
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_levels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Offer one item, hold it until accepted, queue its expected envelope
  task automatic send_item(input logic [1:0] mode, input logic [TIME_BITS-1:0] t,
                           input bit typed, input envelope_t typed_res);
    int        gap;
    envelope_t predicted;
    gap = (quiet || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= mode;
    in_ch.sample_time <= t;
    do @(posedge clk); while (!in_ch.ready);
    predicted = predict_envelope(mode, t);
    expected_levels.push_back(typed ? typed_res : predicted);
    items_sent++;
  endtask

  // Result side: random stalls plus one long hold-off to back the block up
  always @(posedge clk) begin
    if (!pressure_done && items_sent >= PRESSURE_AT) begin
      pressure_done = 1'b1;
      rx_hold = PRESSURE_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold--;
      out_ch.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 3) == 0) begin
      rx_hold = pick_gap() - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_levels.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected result: amplitude %0d phase %0d",
                   out_ch.amplitude, out_ch.phase);
      end else begin
        oldest_level = expected_levels.pop_front();
        if (out_ch.amplitude !== oldest_level.amplitude ||
            out_ch.phase !== oldest_level.phase) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("mismatch: expected amplitude %0d phase %0d, got amplitude %0d phase %0d",
                     oldest_level.amplitude, oldest_level.phase,
                     out_ch.amplitude, out_ch.phase);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("adsr_envelope_generator verification failed");
      $finish;
    end
  end

  initial begin
    envelope_t             typed_res;
    logic [1:0]            mode;
    logic [TIME_BITS-1:0]  t, origin, off, lim_a, lim_b, last_tick;
    logic [DUR_BITS-1:0]   dur_a, dur_d, dur_r;
    logic [LEVEL_BITS-1:0] lvl_s, lvl_p;
    int                    pick;

    rst_n             = 1'b0;
    cfg_psel          = 1'b0;
    cfg_penable       = 1'b0;
    cfg_pwrite        = 1'b0;
    cfg_paddr         = '0;
    cfg_pwdata        = '0;
    in_ch.valid       = 1'b0;
    in_ch.mode        = MODE_SAMPLE;
    in_ch.sample_time = '0;
    out_ch.ready      = 1'b0;
    gate_open         = 1'b0;
    note_on_tick      = '0;
    note_off_tick     = '0;
    atk_len           = ATTACK_RST;
    dec_len           = DECAY_RST;
    rel_len           = RELEASE_RST;
    sus_lvl           = SUSTAIN_RST;
    pk_lvl            = PEAK_RST;
    errors            = 0;
    items_sent        = 0;
    cycle_count       = 0;
    rx_hold           = 0;
    pressure_done     = 1'b0;
    quiet             = 1'b0;
    last_tick         = '0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table
    for (int i = 0; i < NUM_ROWS; i++) begin
      if (DIRECTED[i].kind == ROW_CFG) begin
        wait_drained();
        write_reg(DIRECTED[i].reg_idx, DIRECTED[i].value);
      end else begin
        typed_res.amplitude = DIRECTED[i].amp;
        typed_res.phase     = DIRECTED[i].phase;
        send_item(DIRECTED[i].mode, DIRECTED[i].value, DIRECTED[i].typed, typed_res);
        last_tick = DIRECTED[i].value;
      end
    end

    // Random part, one block of items per register setting
    for (int set_no = 0; set_no < NUM_SETTINGS; set_no++) begin
      wait_drained();
      case (set_no)
        0: begin
          dur_a = DUR_MAX; dur_d = DUR_MAX; dur_r = DUR_MAX;
          lvl_s = LEVEL_MAX; lvl_p = LEVEL_MAX;
        end
        1: begin
          dur_a = DUR_BITS'(1); dur_d = DUR_BITS'(1); dur_r = DUR_BITS'(1);
          lvl_s = '0; lvl_p = LEVEL_MAX;
        end
        2: begin
          dur_a = '0; dur_d = '0; dur_r = '0;
          lvl_s = LEVEL_BITS'($urandom); lvl_p = LEVEL_BITS'($urandom);
        end
        default: begin
          dur_a = pick_duration(); dur_d = pick_duration(); dur_r = pick_duration();
          lvl_s = LEVEL_BITS'($urandom); lvl_p = LEVEL_BITS'($urandom);
        end
      endcase
      // upper bits carry junk; the block must drop them
      write_reg(REG_ATTACK,  {8'($urandom), dur_a});
      write_reg(REG_DECAY,   {8'($urandom), dur_d});
      write_reg(REG_RELEASE, {8'($urandom), dur_r});
      write_reg(REG_SUSTAIN, {16'($urandom), lvl_s});
      write_reg(REG_PEAK,    {16'($urandom), lvl_p});
      for (int idx = NUM_REGS; idx < 2 ** IDX_BITS; idx++)
        write_reg(IDX_BITS'(idx), $urandom);
      quiet = (set_no == 3 || set_no == 5);

      for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 8)       mode = MODE_NOTE_ON;
        else if (pick < 16) mode = MODE_NOTE_OFF;
        else if (pick < 19) mode = MODE_UNUSED;
        else                mode = MODE_SAMPLE;

        if (mode == MODE_NOTE_ON || mode == MODE_NOTE_OFF) begin
          // note events mostly follow the running time, sometimes jump anywhere
          if ($urandom_range(0, 9) == 0)
            t = $urandom;
          else
            t = last_tick + $urandom_range(0, 32'(atk_len) + 32'(dec_len) + 32'(rel_len));
        end else begin
          // samples aim at phase boundaries relative to the last note event
          if (gate_open) begin
            origin = note_on_tick;
            lim_a  = 32'(atk_len);
            lim_b  = 32'(atk_len) + 32'(dec_len);
          end else begin
            origin = note_off_tick;
            lim_a  = 32'(rel_len);
            lim_b  = 32'(rel_len);
          end
          case ($urandom_range(0, 9))
            0:       off = lim_a - 1 + $urandom_range(0, 2);
            1:       off = lim_b - 1 + $urandom_range(0, 2);
            7:       off = $urandom;
            8:       off = $urandom_range(0, 3);
            default: off = $urandom_range(0, lim_b + 2);
          endcase
          t = origin + off;
        end
        send_item(mode, t, 1'b0, typed_res);
        last_tick = t;
      end
    end

    // Drain and finish
    in_ch.valid <= 1'b0;
    while (expected_levels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("adsr_envelope_generator verification clean");
    end else begin
      $display("adsr_envelope_generator verification failed");
    end
    $finish;
  end

endmodule
